// ===== hdl/nidv_pkg.sv =====
`default_nettype none
// ============================================================================
// nidv_pkg
// Shared types, constants and lookup functions for the identity number
// validator.
// ============================================================================
package nidv_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Position thresholds for the character counter.
    localparam logic [4:0] POS_LONG  = 5'd18;
    localparam logic [4:0] POS_SHORT = 5'd15;
    localparam logic [4:0] POS_CHECK = 5'd17;
    localparam logic [4:0] POS_SAT   = 5'd19;

    // Result format codes.
    localparam logic [1:0] FMT_LONG  = 2'd0;
    localparam logic [1:0] FMT_SHORT = 2'd1;
    localparam logic [1:0] FMT_OTHER = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [13:0] CENTURY_BASE = 14'd1900;

    // One finished number, handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  fmt;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  region;
        logic        leap;
        logic        bad;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [3:0] weight(input logic [4:0] pos);
        logic [3:0] w;
        unique case (pos)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] check_char(input logic [3:0] sum);
        logic [7:0] c;
        unique case (sum)
            4'd0:    c = 8'h31;
            4'd1:    c = 8'h30;
            4'd2:    c = 8'h58;
            4'd3:    c = 8'h39;
            4'd4:    c = 8'h38;
            4'd5:    c = 8'h37;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h35;
            4'd8:    c = 8'h34;
            4'd9:    c = 8'h33;
            4'd10:   c = 8'h32;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

    // Reduces a value below 128 modulo 11 by conditional subtraction.
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [6:0] r;
        r = x;
        if (r >= 7'd88) r = r - 7'd88;
        if (r >= 7'd44) r = r - 7'd44;
        if (r >= 7'd22) r = r - 7'd22;
        if (r >= 7'd11) r = r - 7'd11;
        return r[3:0];
    endfunction

    function automatic logic region_ok(input logic [6:0] code);
        logic ok;
        unique case (code)
            7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
            7'd21, 7'd22, 7'd23,
            7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37,
            7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46,
            7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
            7'd61, 7'd62, 7'd63, 7'd64, 7'd65,
            7'd71, 7'd81, 7'd82, 7'd91: ok = 1'b1;
            default:                    ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] lim;
        unique case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    lim = 5'd30;
            7'd2:    lim = leap ? 5'd29 : 5'd28;
            default: lim = 5'd0;
        endcase
        return lim;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nidv_front.sv =====
`default_nettype none
// ============================================================================
// nidv_front
// Takes one character per beat, updates the checksum, region and date
// accumulators, and pushes one finished record on the last character.
// ============================================================================
module nidv_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_take,
    input  wire logic [7:0]        char_code,
    input  wire logic              last_char,
    output      logic              push,
    output      nidv_pkg::rec_t    push_rec
);

    logic [4:0]  pos_reg,    pos_next;
    logic [3:0]  wsum_reg,   wsum_next;
    logic [6:0]  region_reg, region_next;
    logic [13:0] year_reg,   year_next;
    logic [6:0]  cc_reg,     cc_next;
    logic [6:0]  yy_reg,     yy_next;
    logic [6:0]  month_reg,  month_next;
    logic [6:0]  day_reg,    day_next;
    logic        bad_reg,    bad_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [6:0]  digit7;
    logic [6:0]  prod;
    logic [1:0]  fmt;

    assign is_digit = (char_code >= nidv_pkg::ASCII_ZERO) && (char_code <= nidv_pkg::ASCII_NINE);
    assign digit    = is_digit ? 4'(char_code - nidv_pkg::ASCII_ZERO) : 4'd0;
    assign digit7   = {3'b000, digit};
    assign prod     = digit7 * {3'b000, nidv_pkg::weight(pos_reg)};

    always_comb
    begin
        pos_next    = (pos_reg < nidv_pkg::POS_SAT) ? pos_reg + 5'd1 : pos_reg;
        wsum_next   = wsum_reg;
        bad_next    = bad_reg;
        region_next = region_reg;
        year_next   = year_reg;
        cc_next     = cc_reg;
        yy_next     = yy_reg;
        month_next  = month_reg;
        day_next    = day_reg;

        if (pos_reg < nidv_pkg::POS_CHECK)
        begin
            if (!is_digit)
            begin
                bad_next = 1'b1;
            end
            wsum_next = nidv_pkg::mod11(prod + {3'b000, wsum_reg});
        end
        else if (pos_reg == nidv_pkg::POS_CHECK)
        begin
            if (char_code != nidv_pkg::check_char(wsum_reg))
            begin
                bad_next = 1'b1;
            end
        end

        if (pos_reg < 5'd2)
        begin
            region_next = (region_reg << 3) + (region_reg << 1) + digit7;
        end
        if (pos_reg >= 5'd6 && pos_reg <= 5'd9)
        begin
            year_next = (year_reg << 3) + (year_reg << 1) + {10'd0, digit};
        end
        // The century pair doubles as the short-form year, the long-form
        // year pair as the short-form month, and so on.
        if (pos_reg >= 5'd6 && pos_reg <= 5'd7)
        begin
            cc_next = (cc_reg << 3) + (cc_reg << 1) + digit7;
        end
        if (pos_reg >= 5'd8 && pos_reg <= 5'd9)
        begin
            yy_next = (yy_reg << 3) + (yy_reg << 1) + digit7;
        end
        if (pos_reg >= 5'd10 && pos_reg <= 5'd11)
        begin
            month_next = (month_reg << 3) + (month_reg << 1) + digit7;
        end
        if (pos_reg >= 5'd12 && pos_reg <= 5'd13)
        begin
            day_next = (day_reg << 3) + (day_reg << 1) + digit7;
        end
    end

    always_comb
    begin
        priority if (pos_next == nidv_pkg::POS_LONG)
        begin
            fmt = nidv_pkg::FMT_LONG;
        end
        else if (pos_next == nidv_pkg::POS_SHORT)
        begin
            fmt = nidv_pkg::FMT_SHORT;
        end
        else
        begin
            fmt = nidv_pkg::FMT_OTHER;
        end

        push_rec.fmt    = fmt;
        push_rec.region = region_next;
        push_rec.bad    = bad_next;
        unique case (fmt)
            nidv_pkg::FMT_LONG:
            begin
                push_rec.year  = year_next;
                push_rec.month = month_next;
                push_rec.day   = day_next;
                // A century year is leap only when the century is a multiple of four.
                push_rec.leap  = (yy_next != 7'd0) ? (yy_next[1:0] == 2'b00)
                                                    : (cc_next[1:0] == 2'b00);
            end
            nidv_pkg::FMT_SHORT:
            begin
                push_rec.year  = nidv_pkg::CENTURY_BASE + {7'd0, cc_next};
                push_rec.month = yy_next;
                push_rec.day   = month_next;
                push_rec.leap  = (cc_next != 7'd0) && (cc_next[1:0] == 2'b00);
            end
            default:
            begin
                push_rec.year  = 14'd0;
                push_rec.month = 7'd0;
                push_rec.day   = 7'd0;
                push_rec.leap  = 1'b0;
            end
        endcase
    end

    assign push = char_take && last_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wsum_reg   <= '0;
            region_reg <= '0;
            year_reg   <= '0;
            cc_reg     <= '0;
            yy_reg     <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            bad_reg    <= 1'b0;
        end
        else if (push)
        begin
            pos_reg    <= '0;
            wsum_reg   <= '0;
            region_reg <= '0;
            year_reg   <= '0;
            cc_reg     <= '0;
            yy_reg     <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            bad_reg    <= 1'b0;
        end
        else if (char_take)
        begin
            pos_reg    <= pos_next;
            wsum_reg   <= wsum_next;
            region_reg <= region_next;
            year_reg   <= year_next;
            cc_reg     <= cc_next;
            yy_reg     <= yy_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            bad_reg    <= bad_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nidv_queue.sv =====
`default_nettype none
// ============================================================================
// nidv_queue
// Short first-in first-out queue of finished records between the front and
// back ends.
// ============================================================================
module nidv_queue
#(
    parameter int DEPTH = nidv_pkg::QUEUE_DEPTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire nidv_pkg::rec_t          push_rec,
    input  wire logic                    pop,
    output      nidv_pkg::rec_t          head_rec,
    output      nidv_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nidv_pkg::rec_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nidv_back.sv =====
`default_nettype none
// ============================================================================
// nidv_back
// Checks format, error flag, region code and birth date of the record at the
// queue head and holds the verdict in the output register until it is taken.
// ============================================================================
module nidv_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire nidv_pkg::rec_t          head_rec,
    input  wire nidv_pkg::queue_status_t status,
    output      logic                    pop,
    output      logic                    m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output      logic [31:0]             m_axis_tdata,  // birth_year, birth_month, birth_day
    output      logic [2:0]              m_axis_tuser   // id_valid, id_format
);

    logic        out_valid_reg;
    logic [31:0] data_reg;
    logic [2:0]  user_reg;
    logic [4:0]  day_limit;
    logic        date_ok;
    logic        id_ok;

    assign day_limit = nidv_pkg::month_days(head_rec.month, head_rec.leap);
    // An invalid month yields a zero limit, which no day can pass.
    assign date_ok   = (head_rec.day != 7'd0) && (head_rec.day <= {2'b00, day_limit});
    assign id_ok     = (head_rec.fmt != nidv_pkg::FMT_OTHER) && !head_rec.bad
                       && nidv_pkg::region_ok(head_rec.region) && date_ok;

    assign pop = !status.empty && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {4'd0, head_rec.day, head_rec.month, head_rec.year};
            user_reg <= {head_rec.fmt, id_ok};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

endmodule
`default_nettype wire

// ===== hdl/national_id_number_validator.sv =====
`default_nettype none
// ============================================================================
// national_id_number_validator
// Streams an identity number in one character per beat and returns one
// verdict beat per number with format, validity and decoded birth date.
// ============================================================================
// Throughput: one character beat per cycle while the record queue has room,
// back to back across numbers. The record of a number is written into the
// record queue with its last character beat and then into the output register
// once that register is empty or its beat is taken. The input stalls only
// when the record queue is full. Reset: asynchronous, active low; clears all
// accumulators, the queue and the output valid.
module national_id_number_validator
#(
    parameter int QUEUE_DEPTH = nidv_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // char_code
    input  wire logic        s_axis_tlast,  // last_char
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,  // birth_year, birth_month, birth_day
    output      logic [2:0]  m_axis_tuser   // id_valid, id_format
);

    logic                    char_take;
    logic                    push;
    nidv_pkg::rec_t          push_rec;
    nidv_pkg::rec_t          head_rec;
    nidv_pkg::queue_status_t status;
    logic                    pop;

    assign s_axis_tready = !status.full;
    assign char_take     = s_axis_tvalid && s_axis_tready;

    nidv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_take (char_take),
        .char_code (s_axis_tdata),
        .last_char (s_axis_tlast),
        .push      (push),
        .push_rec  (push_rec)
    );

    nidv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (status)
    );

    nidv_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_rec      (head_rec),
        .status        (status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("record pushed into a full queue");

    a_valid_needs_format: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] != nidv_pkg::FMT_OTHER))
        else $error("number of unknown length reported valid");

    a_other_has_no_date: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == nidv_pkg::FMT_OTHER))
            |-> (m_axis_tdata == 32'd0))
        else $error("date fields set for a number of unknown length");

    a_pop_only_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("record taken from an empty queue");

endmodule
`default_nettype wire
